// File: src/hxf_pkg.sv
`timescale 1ns / 1ps
package hxf_pkg;
   localparam int MAX_WINDOW = 32;
   localparam int MAX_ROWS   = 1024;
   localparam int RING_COLS  = MAX_WINDOW + 1;
   localparam int VAL_W      = 32;
   localparam int ROW_W      = 10;
   localparam int COL_W      = 16;
   localparam int PTR_W      = 6;
   localparam int WIN_W      = 6;
   localparam int ROWS_W     = 11;
   localparam int MEM_DEPTH  = RING_COLS * MAX_ROWS;
   localparam int ADDR_W     = PTR_W + ROW_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS  = 1'b1;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [PTR_W-1:0] ptr;
      logic [WIN_W-1:0] win;
      logic             emit;
   } item_type;
endpackage

// File: src/hxf_front.sv
`timescale 1ns / 1ps
module hxf_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [hxf_pkg::VAL_W-1:0]       req_ii_value,
   input  logic                            req_first_of_image,
   input  logic                            csr_write_enable,
   input  logic [hxf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hxf_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            q_full,
   output logic                            q_push,
   output hxf_pkg::item_type               q_item
);
   import hxf_pkg::*;

   logic [WIN_W-1:0]  win_ff;
   logic [ROWS_W-1:0] rows_ff;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [WIN_W-1:0]  win_eff;
   logic [ROWS_W-1:0] rows_eff;
   logic [ROW_W-1:0]  r_cur;
   logic [COL_W-1:0]  c_cur;
   logic [PTR_W-1:0]  p_cur;
   logic              accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;

   always_comb begin
      win_eff = win_ff;
      if (win_ff < WIN_W'(2)) win_eff = WIN_W'(2);
      if (win_ff > WIN_W'(MAX_WINDOW)) win_eff = WIN_W'(MAX_WINDOW);
      rows_eff = rows_ff;
      if (rows_ff == '0) rows_eff = ROWS_W'(1);
      if (rows_ff > ROWS_W'(MAX_ROWS)) rows_eff = ROWS_W'(MAX_ROWS);
      r_cur = req_first_of_image ? '0 : row_ff;
      c_cur = req_first_of_image ? '0 : col_ff;
      p_cur = req_first_of_image ? '0 : ptr_ff;
      q_item.value = req_ii_value;
      q_item.row   = r_cur;
      q_item.col   = c_cur;
      q_item.ptr   = p_cur;
      q_item.win   = win_eff;
      q_item.emit  = ({1'b0, r_cur} >= ROW_W'(win_eff) + (ROW_W+1)'(0))
                     && (c_cur >= COL_W'(win_eff));
      if ((ROWS_W'(r_cur) + ROWS_W'(1)) >= rows_eff) begin
         row_in = '0;
         col_in = c_cur + COL_W'(1);
         ptr_in = (p_cur == PTR_W'(RING_COLS - 1)) ? '0 : p_cur + PTR_W'(1);
      end else begin
         row_in = r_cur + ROW_W'(1);
         col_in = c_cur;
         ptr_in = p_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= WIN_W'(2);
         rows_ff <= ROWS_W'(MAX_ROWS);
         row_ff  <= '0;
         col_ff  <= '0;
         ptr_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_WINDOW_SIZE: win_ff  <= csr_data[WIN_W-1:0];
               CSR_IMAGE_ROWS:  rows_ff <= csr_data[ROWS_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
            ptr_ff <= ptr_in;
         end
      end
   end
endmodule

// File: src/hxf_fifo.sv
`timescale 1ns / 1ps
module hxf_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hxf_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output hxf_pkg::item_type head
);
   import hxf_pkg::*;

   item_type   slot_ff [0:1];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         if (push && !pop) cnt_ff <= cnt_ff + 2'd1;
         else if (pop && !push) cnt_ff <= cnt_ff - 2'd1;
      end
   end
endmodule

// File: src/hxf_back.sv
`timescale 1ns / 1ps
module hxf_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_not_empty,
   input  hxf_pkg::item_type        q_head,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [15:0]       rsp_haar_x,
   output logic signed [15:0]       rsp_haar_y,
   output logic [hxf_pkg::ROW_W-1:0] rsp_out_row,
   output logic [hxf_pkg::COL_W-1:0] rsp_out_col,
   output logic                     rsp_area_valid
);
   import hxf_pkg::*;

   localparam int ACC_W  = VAL_W + 6;
   localparam int DEN_W  = VAL_W + 4;
   localparam int NUM_W  = ACC_W + 16;
   localparam int DCNT_W = $clog2(NUM_W);
   localparam logic [3:0] LAST_READ = 4'd11;

   typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_CHECK, ST_DIV, ST_DONE} state_type;

   state_type               state_ff;
   item_type                cur_ff;
   logic [3:0]              cnt_ff;
   logic signed [ACC_W-1:0] acc_a_ff, acc_x_ff, acc_y_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [NUM_W-1:0]        nx_ff, ny_ff;
   logic [DEN_W-1:0]        remx_ff, remy_ff;
   logic [17:0]             qx_ff, qy_ff;
   logic                    ovfx_ff, ovfy_ff, negx_ff, negy_ff, ok_ff;
   logic [DCNT_W-1:0]       dcnt_ff;
   logic [VAL_W-1:0]        mem [0:MEM_DEPTH-1];
   logic [VAL_W-1:0]        rd_ff;
   logic [ADDR_W-1:0]       raddr, waddr;
   logic                    mem_we;

   logic [3:0]        rj;
   logic [WIN_W-1:0]  m_half, k_back;
   logic [ROW_W-1:0]  up_row, rrow;
   logic [PTR_W:0]    slot_sum;
   logic [PTR_W-1:0]  rslot;
   logic [5:0]        coef;
   logic [DEN_W:0]    remx2, remy2;
   logic              out_load;
   logic [ACC_W-1:0]  magx, magy;
   logic signed [15:0] hx_val, hy_val;

   function automatic logic [5:0] coef_of(input logic [3:0] j);
      // pairs of {area, x, y}: 01 add, 11 subtract, 00 none
      case (j)
         4'd1:    coef_of = 6'b11_11_01;
         4'd2:    coef_of = 6'b01_11_11;
         4'd3:    coef_of = 6'b11_01_11;
         4'd4:    coef_of = 6'b00_01_00;
         4'd5:    coef_of = 6'b00_11_00;
         4'd6:    coef_of = 6'b00_01_00;
         4'd7:    coef_of = 6'b00_11_00;
         4'd8:    coef_of = 6'b00_00_11;
         4'd9:    coef_of = 6'b00_00_11;
         4'd10:   coef_of = 6'b00_00_01;
         4'd11:   coef_of = 6'b00_00_01;
         default: coef_of = 6'b00_00_00;
      endcase
   endfunction

   function automatic logic signed [ACC_W-1:0] apply(input logic signed [ACC_W-1:0] acc,
                                                     input logic [VAL_W-1:0] v,
                                                     input logic [1:0] c);
      logic signed [ACC_W-1:0] ve;
      ve = $signed({{(ACC_W-VAL_W){1'b0}}, v});
      case (c)
         2'b01:   apply = acc + ve;
         2'b11:   apply = acc - ve;
         default: apply = acc;
      endcase
   endfunction

   function automatic logic signed [15:0] sat(input logic [17:0] q, input logic ovf,
                                              input logic neg);
      if (neg) begin
         if (ovf || q > 18'd32768) sat = 16'sh8000;
         else sat = 16'(18'd0 - q);
      end else begin
         if (ovf || q > 18'd32767) sat = 16'sh7fff;
         else sat = 16'(q);
      end
   endfunction

   // corner address for read j of the current window
   always_comb begin
      rj     = cnt_ff + 4'd1;
      m_half = WIN_W'(({1'b0, cur_ff.win} + 7'd1) >> 1);
      up_row = cur_ff.row - ROW_W'(cur_ff.win);
      case (rj)
         4'd1, 4'd8, 4'd9:   k_back = '0;
         4'd4, 4'd5:         k_back = cur_ff.win - m_half;
         4'd6, 4'd7:         k_back = m_half;
         default:            k_back = cur_ff.win;
      endcase
      case (rj)
         4'd3, 4'd5, 4'd7:   rrow = cur_ff.row;
         4'd8, 4'd10:        rrow = up_row + ROW_W'(m_half);
         4'd9, 4'd11:        rrow = cur_ff.row - ROW_W'(m_half);
         default:            rrow = up_row;
      endcase
      slot_sum = (PTR_W+1)'(cur_ff.ptr) + (PTR_W+1)'(RING_COLS) - (PTR_W+1)'(k_back);
      if (slot_sum >= (PTR_W+1)'(RING_COLS)) slot_sum = slot_sum - (PTR_W+1)'(RING_COLS);
      rslot  = slot_sum[PTR_W-1:0];
      raddr  = {rslot, rrow};
      waddr  = {q_head.ptr, q_head.row};
      q_pop  = (state_ff == ST_IDLE) && q_not_empty;
      mem_we = q_pop;
      coef   = coef_of(cnt_ff);
      remx2  = {remx_ff, nx_ff[NUM_W-1]};
      remy2  = {remy_ff, ny_ff[NUM_W-1]};
      magx   = acc_x_ff[ACC_W-1] ? ACC_W'(-acc_x_ff) : ACC_W'(acc_x_ff);
      magy   = acc_y_ff[ACC_W-1] ? ACC_W'(-acc_y_ff) : ACC_W'(acc_y_ff);
      out_load = (state_ff == ST_DONE) && (!rsp_valid || !rsp_stall);
      hx_val = ok_ff ? sat(qx_ff, ovfx_ff, negx_ff) : 16'sd0;
      hy_val = ok_ff ? sat(qy_ff, ovfy_ff, negy_ff) : 16'sd0;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[waddr] <= q_head.value;
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         if (out_load) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
         if (out_load) begin
            rsp_haar_x     <= hx_val;
            rsp_haar_y     <= hy_val;
            rsp_out_row    <= cur_ff.row - ROW_W'(cur_ff.win);
            rsp_out_col    <= cur_ff.col - COL_W'(cur_ff.win);
            rsp_area_valid <= ok_ff;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_not_empty) begin
                  cur_ff   <= q_head;
                  cnt_ff   <= '0;
                  acc_a_ff <= $signed({{(ACC_W-VAL_W){1'b0}}, q_head.value});
                  acc_x_ff <= $signed({{(ACC_W-VAL_W){1'b0}}, q_head.value});
                  acc_y_ff <= $signed({{(ACC_W-VAL_W){1'b0}}, q_head.value});
                  if (q_head.emit) state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               acc_a_ff <= apply(acc_a_ff, rd_ff, coef[5:4]);
               acc_x_ff <= apply(acc_x_ff, rd_ff, coef[3:2]);
               acc_y_ff <= apply(acc_y_ff, rd_ff, coef[1:0]);
               cnt_ff   <= cnt_ff + 4'd1;
               if (cnt_ff == LAST_READ) state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               ok_ff   <= (acc_a_ff > 0);
               den_ff  <= DEN_W'({acc_a_ff, 1'b0});
               nx_ff   <= {magx, 16'd0} + NUM_W'(acc_a_ff);
               ny_ff   <= {magy, 16'd0} + NUM_W'(acc_a_ff);
               negx_ff <= acc_x_ff[ACC_W-1];
               negy_ff <= acc_y_ff[ACC_W-1];
               remx_ff <= '0;
               remy_ff <= '0;
               qx_ff   <= '0;
               qy_ff   <= '0;
               ovfx_ff <= 1'b0;
               ovfy_ff <= 1'b0;
               dcnt_ff <= DCNT_W'(NUM_W - 1);
               state_ff <= (acc_a_ff > 0) ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
               nx_ff <= nx_ff << 1;
               ny_ff <= ny_ff << 1;
               if (remx2 >= {1'b0, den_ff}) begin
                  remx_ff <= DEN_W'(remx2 - {1'b0, den_ff});
                  qx_ff   <= {qx_ff[16:0], 1'b1};
               end else begin
                  remx_ff <= DEN_W'(remx2);
                  qx_ff   <= {qx_ff[16:0], 1'b0};
               end
               if (remy2 >= {1'b0, den_ff}) begin
                  remy_ff <= DEN_W'(remy2 - {1'b0, den_ff});
                  qy_ff   <= {qy_ff[16:0], 1'b1};
               end else begin
                  remy_ff <= DEN_W'(remy2);
                  qy_ff   <= {qy_ff[16:0], 1'b0};
               end
               ovfx_ff <= ovfx_ff | qx_ff[17];
               ovfy_ff <= ovfy_ff | qy_ff[17];
               dcnt_ff <= dcnt_ff - DCNT_W'(1);
               if (dcnt_ff == '0) state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_load) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// File: src/haar_xy_feature_from_integral.sv
`timescale 1ns / 1ps
// channel   direction  handshake           payload
// req       in         req_valid/stall     req_ii_value, req_first_of_image
// rsp       out        rsp_valid/stall     rsp_haar_x/y, rsp_out_row/col, rsp_area_valid
// csr       in         csr_write_enable    csr_index, csr_data
// a sample that makes no window is stored and dropped without leaving the idle state
// a window sample takes 11 column-store reads on one
// read port, then two 54-step radix-2 dividers, one per feature, in lockstep
// reset is synchronous; the column store is not cleared
// a 2-entry queue parts the front from the back; a result waiting under rsp_stall
// holds the back end once the next is ready, and req stalls once the queue is full
module haar_xy_feature_from_integral (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [31:0]                     req_ii_value,
   input  logic                            req_first_of_image,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [15:0]              rsp_haar_x,
   output logic signed [15:0]              rsp_haar_y,
   output logic [9:0]                      rsp_out_row,
   output logic [15:0]                     rsp_out_col,
   output logic                            rsp_area_valid,
   input  logic                            csr_write_enable,
   input  logic [hxf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hxf_pkg::CSR_DATA_W-1:0]  csr_data
);
   import hxf_pkg::*;

   item_type push_item, head;
   logic     push, full, pop, not_empty;

   hxf_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_ii_value, .req_first_of_image,
      .csr_write_enable, .csr_index, .csr_data,
      .q_full(full), .q_push(push), .q_item(push_item)
   );

   hxf_fifo u_fifo (
      .clock, .reset, .push, .push_item, .full, .pop, .not_empty, .head
   );

   hxf_back u_back (
      .clock, .reset, .q_not_empty(not_empty), .q_head(head), .q_pop(pop),
      .rsp_valid, .rsp_stall, .rsp_haar_x, .rsp_haar_y, .rsp_out_row,
      .rsp_out_col, .rsp_area_valid
   );
endmodule

// File: verif/haar_xy_feature_from_integral_test.sv
`timescale 1ns / 1ps
module haar_xy_feature_from_integral_test;
   import hxf_pkg::*;

   typedef struct {
      logic signed [15:0] haar_x;
      logic signed [15:0] haar_y;
      logic [9:0]         top_row;
      logic [15:0]        left_col;
      logic               area_ok;
   } feature_type;

   typedef struct {
      logic [31:0] base;
      logic [31:0] slope [3];
      feature_type want;
   } corner_case_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [31:0] req_ii_value = 0;
   logic req_first_of_image = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [15:0] rsp_haar_x, rsp_haar_y;
   logic [9:0] rsp_out_row;
   logic [15:0] rsp_out_col;
   logic rsp_area_valid;
   logic csr_write_enable = 0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_WINDOW_SIZE;
   logic [CSR_DATA_W-1:0] csr_data = 0;

   haar_xy_feature_from_integral u_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // model state
   logic [31:0] ring_mem [RING_COLS*MAX_ROWS];
   logic [9:0]  cur_row;
   logic [15:0] cur_col;
   int          ring_ptr;
   logic [5:0]  win_reg;
   logic [10:0] rows_reg;

   feature_type feature_q [$];
   feature_type pinned [int];
   int accepted_n, sent_n, errors, quiet_cycles;
   bit no_idle, hold_off;

   function automatic longint ring_rd(int back, int row);
      int slot;
      slot = (ring_ptr + RING_COLS - (back % RING_COLS)) % RING_COLS;
      return longint'({32'b0, ring_mem[slot*MAX_ROWS + row % MAX_ROWS]});
   endfunction

   function automatic logic signed [15:0] to_q15(longint num, longint den);
      logic [63:0] mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag * 65536 + den) / (2 * den);
      if (num < 0) begin
         if (q > 32768) q = 32768;
         return -q[15:0];
      end
      if (q > 32767) q = 32767;
      return q[15:0];
   endfunction

   function automatic bit window_feature(logic [31:0] v, logic first, output feature_type f);
      int s, nrows, r, c, m, up, dn;
      longint area, a_r, a_l, a_t, a_b;
      bit hit;
      s = (win_reg < 2) ? 2 : (win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg;
      nrows = (rows_reg < 1) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
      if (first) begin
         cur_row = 0;
         cur_col = 0;
         ring_ptr = 0;
      end
      r = cur_row;
      c = cur_col;
      ring_mem[ring_ptr*MAX_ROWS + r] = v;
      hit = (r >= s) && (c >= s);
      f = '{0, 0, 0, 0, 0};
      if (hit) begin
         m = (s + 1) / 2;
         up = r - s;
         dn = r;
         area = ring_rd(0, dn) + ring_rd(s, up) - ring_rd(0, up) - ring_rd(s, dn);
         if (area > 0) begin
            a_r = ring_rd(0, dn) + ring_rd(s-m, up) - ring_rd(0, up) - ring_rd(s-m, dn);
            a_l = ring_rd(m, dn) + ring_rd(s, up) - ring_rd(m, up) - ring_rd(s, dn);
            a_t = ring_rd(0, dn-m) + ring_rd(s, up) - ring_rd(0, up) - ring_rd(s, dn-m);
            a_b = ring_rd(0, dn) + ring_rd(s, up+m) - ring_rd(0, up+m) - ring_rd(s, dn);
            f.haar_x = to_q15(a_r - a_l, area);
            f.haar_y = to_q15(a_b - a_t, area);
            f.area_ok = 1;
         end
         f.top_row = 10'(up);
         f.left_col = 16'(c - s);
      end
      if (r + 1 >= nrows) begin
         cur_row = 0;
         cur_col = 16'(c + 1);
         ring_ptr = (ring_ptr + 1) % RING_COLS;
      end else begin
         cur_row = 10'(r + 1);
      end
      return hit;
   endfunction

   // monitor and scoreboard
   always @(posedge clock) begin
      feature_type f, e;
      if (reset) begin
         cur_row = 0;
         cur_col = 0;
         ring_ptr = 0;
         win_reg = 2;
         rows_reg = 1024;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_WINDOW_SIZE) win_reg = csr_data[5:0];
            else rows_reg = csr_data;
         end
         if (req_valid && !req_stall) begin
            if (window_feature(req_ii_value, req_first_of_image, f)) begin
               if (pinned.exists(accepted_n)) f = pinned[accepted_n];
               feature_q.push_back(f);
            end
            accepted_n++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (feature_q.size() == 0) begin
               $error("unexpected transfer on rsp");
               errors++;
            end else begin
               e = feature_q.pop_front();
               if (rsp_haar_x !== e.haar_x) begin
                  $error("haar_x exp %0d got %0d", e.haar_x, rsp_haar_x); errors++;
               end
               if (rsp_haar_y !== e.haar_y) begin
                  $error("haar_y exp %0d got %0d", e.haar_y, rsp_haar_y); errors++;
               end
               if (rsp_out_row !== e.top_row) begin
                  $error("out_row exp %0d got %0d", e.top_row, rsp_out_row); errors++;
               end
               if (rsp_out_col !== e.left_col) begin
                  $error("out_col exp %0d got %0d", e.left_col, rsp_out_col); errors++;
               end
               if (rsp_area_valid !== e.area_ok) begin
                  $error("area_valid exp %0d got %0d", e.area_ok, rsp_area_valid);
                  errors++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= 5000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver
   initial begin
      int pick;
      @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end else if (no_idle) begin
            rsp_stall <= 0;
            @(posedge clock);
         end else begin
            pick = $urandom_range(0, 99);
            rsp_stall <= (pick >= 60);
            if (pick < 60) repeat ($urandom_range(1, 20)) @(posedge clock);
            else if (pick < 95) repeat ($urandom_range(1, 3)) @(posedge clock);
            else repeat ($urandom_range(20, 60)) @(posedge clock);
         end
      end
   end

   task automatic send(logic [31:0] v, logic first);
      int pick, gap;
      req_valid <= 1;
      req_ii_value <= v;
      req_first_of_image <= first;
      do @(posedge clock); while (req_stall);
      sent_n++;
      pick = $urandom_range(0, 99);
      gap = no_idle ? 0 : (pick < 70) ? 0 : (pick < 95) ? $urandom_range(1, 3)
                                                          : $urandom_range(10, 40);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (feature_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   // one image of synthetic integral values, column major
   task automatic run_image(int win, int rows, int n_items, int mode, bit may_cut);
      logic [31:0] prev_col [MAX_ROWS];
      logic [31:0] sum, v, px;
      int r, eff_rows, cut_at;
      bit first;
      csr_write(CSR_WINDOW_SIZE, CSR_DATA_W'(win));
      csr_write(CSR_IMAGE_ROWS, CSR_DATA_W'(rows));
      eff_rows = (rows < 1) ? 1 : (rows > MAX_ROWS) ? MAX_ROWS : rows;
      cut_at = may_cut ? $urandom_range(1, n_items - 1) : -1;
      r = 0;
      sum = 0;
      first = 1;
      for (int i = 0; i < n_items; i++) begin
         if (i == cut_at && r > 0) begin
            drain();
            eff_rows = $urandom_range(1, r);
            csr_write(CSR_IMAGE_ROWS, CSR_DATA_W'(eff_rows));
         end
         if (!first && $urandom_range(0, 99) == 0) begin
            first = 1;
            r = 0;
            sum = 0;
         end
         if (first) foreach (prev_col[k]) prev_col[k] = 0;
         case (mode)
            0: px = $urandom_range(0, 255);
            1: px = $urandom_range(0, 1 << 24);
            2: px = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
            default: px = $urandom;
         endcase
         sum += px;
         v = (mode == 3 || $urandom_range(0, 15) == 0) ? $urandom : prev_col[r] + sum;
         send(v, first);
         first = 0;
         prev_col[r] = v;
         if (r + 1 >= eff_rows) begin
            r = 0;
            sum = 0;
         end else begin
            r++;
         end
      end
      drain();
   endtask

   corner_case_type corner_cases [3] = '{
      '{32'hFFFF_FFFF, '{0, 0, 0}, '{16'sd0, 16'sd0, 10'd0, 16'd0, 1'b0}},
      '{32'h0, '{0, 0, 5}, '{16'sd32767, 16'sd0, 10'd0, 16'd0, 1'b1}},
      '{32'h0, '{0, 5, 5}, '{-16'sd32768, 16'sd0, 10'd0, 16'd0, 1'b1}}
   };

   initial begin
      int s, rows, cols, picks [8];
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // 2x2 window on a 3x3 image: one window per case
      csr_write(CSR_IMAGE_ROWS, 3);
      csr_write(CSR_WINDOW_SIZE, 2);
      foreach (corner_cases[i]) begin
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               if (c == 2 && r == 2) pinned[sent_n] = corner_cases[i].want;
               send(corner_cases[i].base + corner_cases[i].slope[c] * r, c == 0 && r == 0);
            end
         end
      end
      drain();

      // range extremes: largest window, too many/few rows, window 1
      run_image(63, 33, 33 * 33, 0, 0);
      run_image(33, 2047, 60, 3, 0);
      run_image(0, 0, 30, 3, 0);
      hold_off = 1;
      run_image(1, 5, 30, 1, 0);

      picks = '{0, 1, 2, 3, 4, 5, 6, 8};
      while (sent_n < 1350) begin
         no_idle = ($urandom_range(0, 3) == 0);
         s = picks[$urandom_range(0, 7)];
         rows = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
         cols = (s < 2 ? 2 : s) + $urandom_range(1, 6);
         run_image(s, rows, cols * (rows < 1 ? 1 : rows), $urandom_range(0, 3),
                   $urandom_range(0, 3) == 0);
      end
      no_idle = 0;

      if (errors == 0 && feature_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// File: haar_xy_feature_from_integral.f
src/hxf_pkg.sv
src/hxf_front.sv
src/hxf_fifo.sv
src/hxf_back.sv
src/haar_xy_feature_from_integral.sv
verif/haar_xy_feature_from_integral_test.sv
